/* design/i2a_pkg.sv */
package i2a_pkg;

  // Input and text geometry
  localparam int unsigned ValueW    = 32;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned BcdW      = MaxDigits * DigitW;
  localparam int unsigned DigitIdxW = $clog2(MaxDigits);
  localparam int unsigned StepCntW  = $clog2(ValueW);

  // Queue between converter and emitter
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // ASCII codes
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharMinus = 8'd45;

  // One converted value: sign, index of the leading digit, packed BCD digits
  typedef struct packed {
    logic                 negative;
    logic [DigitIdxW-1:0] top_idx;
    logic [BcdW-1:0]      bcd;
  } num_t;

endpackage

/* design/int32_to_decimal_ascii_unit.sv */
// Converts a signed 32-bit value into its decimal ASCII text, most significant
// character first: '-' for a negative value, then the digits without leading
// zeros (zero gives one '0'); -2147483648 converts exactly. Each character is
// shown on character_o for one cycle with valid_o high, and last_o marks the
// final character of a value; the receiver cannot stall, so characters must be
// taken as they come. A value is transferred when start_i is high and busy_o is
// low. The converter shifts one input bit per cycle into a BCD register and stays
// busy until it has pushed the result into a two-entry queue; the emitter sends one
// character a cycle (1 to 11 per value) while the queue holds an entry, overlapping
// the next conversion, and each character passes through an output register.
module int32_to_decimal_ascii_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [i2a_pkg::ValueW-1:0] value_i,
  output logic                       busy_o,
  output logic                       valid_o,
  output logic [7:0]                 character_o,
  output logic                       last_o
);
  import i2a_pkg::*;

  num_t push_data;
  num_t head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  i2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  i2a_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  i2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .valid_o     (valid_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

/* design/i2a_front.sv */
module i2a_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [i2a_pkg::ValueW-1:0]     value_i,
  output logic                           busy_o,
  input  logic                           full_i,
  output logic                           push_o,
  output i2a_pkg::num_t                  push_data_o
);
  import i2a_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StPush = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [ValueW-1:0]   mag_q, mag_d;
  logic [BcdW-1:0]     bcd_q, bcd_d, bcd_adj;
  logic                neg_q, neg_d;
  logic [DigitIdxW-1:0] top_idx;
  logic                 accept;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && !busy_o;

  // Double-dabble correction: bump every digit of five or more by three
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < MaxDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] >= DigitW'(5)) begin
        bcd_adj[i*DigitW +: DigitW] = bcd_q[i*DigitW +: DigitW] + DigitW'(3);
      end
    end
  end

  // Leading nonzero digit; zero keeps index 0 so a single '0' goes out
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < MaxDigits; i++) begin
      if (bcd_q[i*DigitW +: DigitW] != '0) begin
        top_idx = DigitIdxW'(i);
      end
    end
  end

  assign push_o                = (state_q == StPush) && !full_i;
  assign push_data_o.negative  = neg_q;
  assign push_data_o.top_idx   = top_idx;
  assign push_data_o.bcd       = bcd_q;

  // Sequencer: load magnitude, shift one bit per cycle, hand off
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          neg_d   = value_i[ValueW-1];
          mag_d   = value_i[ValueW-1] ? (ValueW'(0) - value_i) : value_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        {bcd_d, mag_d} = {bcd_adj, mag_q} << 1;
        cnt_d          = cnt_q + StepCntW'(1);
        if (cnt_q == StepCntW'(ValueW - 1)) begin
          state_d = StPush;
        end
      end
      StPush: begin
        if (!full_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

endmodule

/* design/i2a_queue.sv */
module i2a_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  i2a_pkg::num_t push_data_i,
  input  logic          pop_i,
  output i2a_pkg::num_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import i2a_pkg::*;

  num_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QueueCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QueueCntW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* design/i2a_back.sv */
module i2a_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  i2a_pkg::num_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          valid_o,
  output logic [7:0]    character_o,
  output logic          last_o
);
  import i2a_pkg::*;

  logic                 started_q;
  logic [DigitIdxW-1:0] idx_q;
  logic [DigitIdxW-1:0] cur_idx;
  logic                 emit_sign;
  logic                 emit_last;
  logic                 valid_q;
  logic [7:0]           char_q;
  logic                 last_q;

  // Sign goes first on a fresh negative entry, then digits top down
  assign cur_idx   = started_q ? idx_q : head_i.top_idx;
  assign emit_sign = !started_q && head_i.negative;
  assign emit_last = !emit_sign && (cur_idx == '0);
  assign pop_o     = !empty_i && emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      idx_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= !empty_i;
      if (!empty_i) begin
        priority if (emit_sign) begin
          started_q <= 1'b1;
          idx_q     <= head_i.top_idx;
        end else if (emit_last) begin
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          idx_q     <= cur_idx - DigitIdxW'(1);
        end
      end
    end
  end

  // Output register: one character per cycle while the queue holds an entry
  always_ff @(posedge clk_i) begin
    char_q <= emit_sign ? CharMinus
                        : CharZero + {4'd0, head_i.bcd[cur_idx*DigitW +: DigitW]};
    last_q <= emit_last;
  end

  assign valid_o     = valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

/* dv/i2a_text_checker.sv */
// Watches the value and character channels of the converter, predicts the
// decimal text of each transferred value and compares every character with it.
module i2a_text_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [i2a_pkg::ValueW-1:0] value_i,
  input  logic                       valid_i,
  input  logic [7:0]                 character_i,
  input  logic                       last_i,
  output int unsigned                errors_o,
  output int unsigned                pending_o,
  output int unsigned                chars_o
);
  import i2a_pkg::*;

  localparam logic [ValueW-1:0] Radix = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  // Characters still to come, oldest first
  text_char_t  expected_text_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned char_cnt     = 0;

  // Append the text of one value: optional sign, then digits msd first
  function automatic void push_decimal_text(input logic [ValueW-1:0] value);
    logic              negative;
    logic [ValueW-1:0] magnitude;
    logic [7:0]        digit_codes[MaxDigits];
    int                n_digits;
    int                k;
    negative  = value[ValueW-1];
    // unsigned negate keeps the most negative value exact
    magnitude = negative ? (~value + 1'b1) : value;
    n_digits  = 0;
    do begin
      digit_codes[n_digits] = CharZero + 8'(magnitude % Radix);
      magnitude = magnitude / Radix;
      n_digits++;
    end while (magnitude != 0 && n_digits < MaxDigits);
    if (negative) begin
      expected_text_q.push_back('{code: CharMinus, last: 1'b0});
    end
    for (k = n_digits - 1; k >= 0; k--) begin
      expected_text_q.push_back('{code: digit_codes[k], last: (k == 0)});
    end
  endfunction

  // Results first: a character can never belong to a value transferred at the same edge
  always @(posedge clk_i) begin : check_p
    text_char_t want;
    if (rst_ni) begin
      if (valid_i) begin
        char_cnt++;
        if (expected_text_q.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected character %0d last %0b, nothing pending",
                   $time, character_i, last_i);
        end else begin
          want = expected_text_q.pop_front();
          if (character_i !== want.code) begin
            mismatch_cnt++;
            $display("%0t: character mismatch: expected %0d ('%c') actual %0d ('%c')",
                     $time, want.code, want.code, character_i, character_i);
          end
          if (last_i !== want.last) begin
            mismatch_cnt++;
            $display("%0t: end marker mismatch on '%c': expected %0b actual %0b",
                     $time, want.code, want.last, last_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        push_decimal_text(value_i);
      end
    end
    errors_o  <= mismatch_cnt;
    pending_o <= expected_text_q.size();
    chars_o   <= char_cnt;
  end

endmodule

/* dv/tb.sv */
// Drives signed values into the converter with random gaps; the checker
// predicts and compares the text, this module gives the verdict.
module tb;
  import i2a_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned RandomItems = 360;
  localparam int unsigned SteadyItems = 40;
  localparam int unsigned NumDirected = 22;

  // Zero, single digits, digit-count boundaries, both extremes, bit patterns
  localparam logic [ValueW-1:0] DirectedValues[NumDirected] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd100,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'sd999999999, -32'sd1000000000, 32'd1234567890, -32'sd1234567890,
    32'h5555_5555, 32'haaaa_aaaa, 32'd7, -32'sd9
  };

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start_i = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              busy_o;
  logic              valid_o;
  logic [7:0]        character_o;
  logic              last_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned chars;
  int unsigned cycle_cnt   = 0;
  int unsigned values_sent = 0;

  int32_to_decimal_ascii_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .valid_o    (valid_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  i2a_text_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .value_i    (value_i),
    .valid_i    (valid_o),
    .character_i(character_o),
    .last_i     (last_o),
    .errors_o   (errors),
    .pending_o  (pending),
    .chars_o    (chars)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  // Hold start high until a transfer; busy is stable at the falling edge
  task automatic send_value(input logic [ValueW-1:0] value);
    bit taken;
    start_i <= 1'b1;
    value_i <= value;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
    values_sent++;
  endtask

  task automatic hold_off(input int unsigned n_cycles);
    start_i <= 1'b0;
    repeat (n_cycles) @(posedge clk_i);
  endtask

  // Mostly values of a chosen digit count, plus raw words and tiny values
  function automatic logic [ValueW-1:0] random_value();
    longint unsigned   scale;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   magnitude;
    int unsigned       n_digits;
    bit                negative;
    logic [ValueW-1:0] value;
    negative = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: begin
        magnitude = 64'($urandom);
      end
      3: begin
        magnitude = 64'($urandom_range(0, 20));
      end
      default: begin
        n_digits = $urandom_range(1, MaxDigits);
        scale = 1;
        repeat (n_digits - 1) scale = scale * 10;
        lo = (n_digits == 1) ? 0 : scale;
        hi = scale * 10 - 1;
        if (negative && hi > 64'h8000_0000) hi = 64'h8000_0000;
        if (!negative && hi > 64'h7fff_ffff) hi = 64'h7fff_ffff;
        magnitude = lo + ({$urandom, $urandom} % (hi - lo + 1));
      end
    endcase
    value = ValueW'(magnitude);
    if (negative) value = -value;
    return value;
  endfunction

  initial begin : stimulus_p
    bit gappy;
    int unsigned i;
    gappy = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed values, every third with a pause behind it
    for (i = 0; i < NumDirected; i++) begin
      send_value(DirectedValues[i]);
      if (i % 3 == 2) hold_off($urandom_range(1, 13));
    end

    // Random values; pauses come and go in stretches, none near the end
    for (i = 0; i < RandomItems; i++) begin
      if (i % 30 == 0) gappy = 1'($urandom_range(0, 1));
      if (i < RandomItems - SteadyItems && gappy && $urandom_range(0, 2) == 0) begin
        hold_off($urandom_range(1, 13));
      end
      send_value(random_value());
    end
    start_i <= 1'b0;

    // Drain outstanding characters, then let the pipeline settle
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Converted %0d values (zero, both extremes, every digit count, both signs)",
             values_sent);
    $display("into %0d checked characters, %0d mismatches", chars, errors);
    if (errors == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* int32_to_decimal_ascii_unit.f */
design/i2a_pkg.sv
design/i2a_front.sv
design/i2a_queue.sv
design/i2a_back.sv
design/int32_to_decimal_ascii_unit.sv
dv/i2a_text_checker.sv
dv/tb.sv
